// ===== hdl/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants for the run-length frame token decoder
// Token opcodes, decoder phase and token kind encodings, and register reset.
// ----------------------------------------------------------------------------
package rfd_pkg;

    // High nibble of an opcode byte. Nibbles below OP_BLACK are inverting runs.
    localparam logic [3:0] OP_INVERT_LAST = 4'hB;
    localparam logic [3:0] OP_BLACK       = 4'hC;
    localparam logic [3:0] OP_WHITE       = 4'hD;
    localparam logic [3:0] OP_GRAY16      = 4'hE;
    localparam logic [3:0] OP_GRAY8       = 4'hF;

    localparam logic [7:0] COLOR_BLACK = 8'h00;
    localparam logic [7:0] COLOR_WHITE = 8'hFF;

    localparam int RUN_W   = 17;
    localparam int COUNT_W = 16;

    // A frame register of zero stands for the full 16-bit range.
    localparam logic [RUN_W-1:0]   FRAME_MAX          = 17'h10000;
    localparam logic [COUNT_W-1:0] FRAME_PIXELS_RESET = 16'(160 * 160);

    typedef enum logic [2:0] {
        PH_OPCODE = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BLACK  = 2'd0,
        KIND_WHITE  = 2'd1,
        KIND_GRAY16 = 2'd2,
        KIND_GRAY8  = 2'd3
    } kind_t;

endpackage

// ===== hdl/rle_frame_token_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rle_frame_token_decoder_top: run-length frame token decoder
// Assembles one- to three-byte tokens into (color, run) results with frame
// end detection and clipping of runs that pass the end of the frame.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                        Direction
//  -------   --------------------------------------------   ---------
//  input     in_valid, in_ready, data_byte                  in
//  output    out_valid, out_ready, pixel_color, run_length,  out
//            frame_end, overrun
//  config    cfg_wr_en, cfg_wr_data (frame_pixels)          in
//
//  One byte is taken per cycle while in_ready is high. The byte that
//  completes a token loads the result register, so its result appears
//  in the cycle after its transfer. The result register is the only
//  buffer: when it holds a result that is not taken, in_ready drops
//  until out_ready returns. Reset clears the decoder to expect an opcode,
//  black color, count zero, and sets frame_pixels to 25600.
//
module rle_frame_token_decoder_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  pixel_color,
    output logic [rfd_pkg::RUN_W-1:0]   run_length,
    output logic                        frame_end,
    output logic                        overrun,
    input  logic                        cfg_wr_en,
    input  logic [rfd_pkg::COUNT_W-1:0] cfg_wr_data
);
    import rfd_pkg::*;

    phase_t               phase_reg, phase_next;
    kind_t                kind_reg, kind_next;
    logic [RUN_W-1:0]     partial_reg, partial_next;
    logic [7:0]           cur_color_reg, cur_color_next;
    logic [7:0]           pend_color_reg, pend_color_next;
    logic [COUNT_W-1:0]   filled_reg, filled_next;
    logic [COUNT_W-1:0]   frame_pixels_reg;

    logic                 out_valid_reg;
    logic [7:0]           color_out_reg;
    logic [RUN_W-1:0]     run_out_reg;
    logic                 end_out_reg;
    logic                 over_out_reg;

    logic                 in_fire;
    logic                 emit;
    logic [RUN_W-1:0]     emit_run;
    logic [7:0]           emit_color;
    logic [RUN_W-1:0]     frame_size;
    logic [RUN_W-1:0]     filled_ext;
    logic [RUN_W-1:0]     remaining;
    logic                 clip;
    logic [RUN_W-1:0]     len;
    logic                 over;
    logic [3:0]           hi_nib;
    logic [3:0]           lo_nib;
    logic [RUN_W-1:0]     byte_plus_one;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign hi_nib        = data_byte[7:4];
    assign lo_nib        = data_byte[3:0];
    assign byte_plus_one = {9'd0, data_byte} + RUN_W'(1);

    // Token assembly: decide whether this byte finishes a token and with
    // which run and color.
    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        partial_next    = partial_reg;
        pend_color_next = pend_color_reg;
        emit            = 1'b0;
        emit_run        = byte_plus_one;
        emit_color      = pend_color_reg;

        unique case (phase_reg)
            PH_OPCODE:
            begin
                unique case (hi_nib) inside
                    [4'h0:OP_INVERT_LAST]:
                    begin
                        emit       = 1'b1;
                        emit_color = ~cur_color_reg;
                    end
                    OP_BLACK, OP_WHITE:
                    begin
                        kind_next       = (hi_nib == OP_BLACK) ? KIND_BLACK : KIND_WHITE;
                        pend_color_next = (hi_nib == OP_BLACK) ? COLOR_BLACK : COLOR_WHITE;
                        partial_next    = {13'd0, lo_nib} + RUN_W'(1);
                        phase_next      = PH_SECOND;
                    end
                    default:
                    begin
                        kind_next       = (hi_nib == OP_GRAY16) ? KIND_GRAY16 : KIND_GRAY8;
                        pend_color_next = {lo_nib, lo_nib};
                        partial_next    = '0;
                        phase_next      = PH_SECOND;
                    end
                endcase
            end
            PH_SECOND:
            begin
                case (kind_reg)
                    KIND_GRAY16:
                    begin
                        partial_next = byte_plus_one;
                        phase_next   = PH_THIRD;
                    end
                    KIND_GRAY8:
                    begin
                        emit = 1'b1;
                    end
                    default:
                    begin
                        emit     = 1'b1;
                        emit_run = partial_reg + {5'd0, data_byte, 4'd0};
                    end
                endcase
            end
            PH_THIRD:
            begin
                emit     = 1'b1;
                emit_run = partial_reg + {1'b0, data_byte, 8'd0};
            end
            default:
            begin
                phase_next = PH_OPCODE;
            end
        endcase
    end

    // Frame accounting for a finished token.
    assign frame_size = (frame_pixels_reg == '0) ? FRAME_MAX : {1'b0, frame_pixels_reg};
    assign filled_ext = {1'b0, filled_reg};
    assign remaining  = (filled_ext < frame_size) ? (frame_size - filled_ext) : '0;
    assign clip       = (emit_run >= remaining);
    assign len        = clip ? remaining : emit_run;
    assign over       = (emit_run > remaining);

    always_comb
    begin
        cur_color_next = cur_color_reg;
        filled_next    = filled_reg;
        if (emit)
        begin
            if (clip)
            begin
                cur_color_next = COLOR_BLACK;
                filled_next    = '0;
            end
            else
            begin
                cur_color_next = emit_color;
                filled_next    = filled_reg + emit_run[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_OPCODE;
            kind_reg       <= KIND_BLACK;
            partial_reg    <= '0;
            cur_color_reg  <= COLOR_BLACK;
            pend_color_reg <= COLOR_BLACK;
            filled_reg     <= '0;
        end
        else if (in_fire)
        begin
            kind_reg       <= kind_next;
            pend_color_reg <= pend_color_next;
            cur_color_reg  <= cur_color_next;
            filled_reg     <= filled_next;
            if (emit)
            begin
                phase_reg   <= PH_OPCODE;
                partial_reg <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end
        else if (cfg_wr_en)
        begin
            frame_pixels_reg <= cfg_wr_data;
        end
    end

    // Result register: loaded by the byte that finishes a token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            color_out_reg <= emit_color;
            run_out_reg   <= len;
            end_out_reg   <= clip;
            over_out_reg  <= over;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_out_reg;
    assign run_length  = run_out_reg;
    assign frame_end   = end_out_reg;
    assign overrun     = over_out_reg;

    // An overrun is always reported together with the end of the frame.
    a_overrun_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!over_out_reg || end_out_reg))
        else $error("overrun reported without frame end");

    // A run that does not end the frame is never empty.
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !end_out_reg) |-> (run_out_reg != '0))
        else $error("empty run without frame end");

    // The third byte of a token only follows a 16-bit gray opcode.
    a_third_is_gray16: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_THIRD) |-> (kind_reg == KIND_GRAY16))
        else $error("third token byte for a short token");

    // Ending a frame restarts the count and the color.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && emit && clip) |=> (filled_reg == '0 && cur_color_reg == COLOR_BLACK
                                       && phase_reg == PH_OPCODE))
        else $error("frame end did not restart the decoder");

endmodule
